// ===== src/bhpq_pkg.sv =====
// ----------------------------------------------------------------------------
// bhpq_pkg
// Shared types and constants for the binary min-heap priority queue.
// ----------------------------------------------------------------------------
package bhpq_pkg;

  localparam int DefaultHeapDepth = 128;
  localparam int DataW            = 8;
  localparam int PrioW            = 16;
  localparam int CountW           = 7;
  localparam int StatusW          = 2;

  localparam logic CmdInsert = 1'b0;
  localparam logic CmdRemove = 1'b1;

  typedef enum logic [StatusW-1:0] {
    StatusOk    = 2'd0,
    StatusEmpty = 2'd1,
    StatusFull  = 2'd2
  } status_e;

  typedef struct packed {
    logic [PrioW-1:0] prio;
    logic [DataW-1:0] data;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

endpackage

// ===== src/bhpq_if.sv =====
// ----------------------------------------------------------------------------
// bhpq_req_if / bhpq_rsp_if
// Valid/ready channels for request items and result items of the heap.
// ----------------------------------------------------------------------------
interface bhpq_req_if import bhpq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             command;
  logic [DataW-1:0] entry_data;
  logic [PrioW-1:0] entry_priority;

  modport source (output valid, command, entry_data, entry_priority, input ready);
  modport sink   (input valid, command, entry_data, entry_priority, output ready);
endinterface

interface bhpq_rsp_if import bhpq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DataW-1:0]   removed_data;
  logic [StatusW-1:0] status;
  logic [CountW-1:0]  entry_count;
  logic               is_empty;

  modport source (output valid, removed_data, status, entry_count, is_empty, input ready);
  modport sink   (input valid, removed_data, status, entry_count, is_empty, output ready);
endinterface

// ===== src/bhpq_ram.sv =====
// ----------------------------------------------------------------------------
// bhpq_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module bhpq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_a_i,
  input  logic [AddrW-1:0] raddr_b_i,
  output logic [Width-1:0] rdata_a_o,
  output logic [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ===== src/binary_min_heap_priority_queue.sv =====
// ----------------------------------------------------------------------------
// binary_min_heap_priority_queue
// Min-heap priority queue held in one two-read, one-write RAM, root at slot 1.
//
// Usage:
//   req_i carries items: command (insert / remove), entry_data, entry_priority.
//   rsp_o returns one result per item: removed_data, status, entry_count,
//   is_empty. Smallest priority leaves first; ties go to the left child.
//   One item is processed at a time. An insert does one RAM read/compare/write
//   per level that it climbs; a remove first fetches the root and the last
//   entry, then does one read/compare/write per level, with both children
//   read at once.
//   Remove on an empty heap and insert on a full heap (HeapDepth-1 entries)
//   report an error status and change nothing.
//   Reset clears the entry count; RAM contents are not cleared.
//   A stalled result stays in the output register; the next item can be
//   accepted and worked on, and its result waits until the register frees.
// ----------------------------------------------------------------------------
module binary_min_heap_priority_queue import bhpq_pkg::*; #(
  parameter int HeapDepth = DefaultHeapDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  bhpq_req_if.sink     req_i,
  bhpq_rsp_if.source   rsp_o
);

  localparam int AW  = $clog2(HeapDepth);
  localparam int PW  = AW + 1;
  localparam int CXW = (AW > CountW) ? AW : CountW;

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StUp     = 3'd1;
  localparam logic [2:0] StDnLoad = 3'd2;
  localparam logic [2:0] StDnCmp  = 3'd3;
  localparam logic [2:0] StFin    = 3'd4;
  localparam logic [2:0] StDone   = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [AW-1:0]    cnt_q, cnt_d;
  logic [AW-1:0]    pos_q, pos_d;
  entry_t           new_q, new_d;
  logic [DataW-1:0] top_q, top_d;
  status_e          status_q, status_d;

  logic               out_valid_q;
  logic [DataW-1:0]   out_data_q;
  status_e            out_status_q;
  logic [CountW-1:0]  out_cnt_q;
  logic               out_empty_q;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_ra_a, ram_ra_b;
  entry_t        ram_wdata, rd_a, rd_b;

  logic          in_acc, out_free;
  logic [AW-1:0] ins_pos, up;
  logic [PW-1:0] child_l, child_r, n_ext, cc_l;
  logic          use_r;
  logic [PW-1:0] c_sel;
  entry_t        c_val;
  logic [CXW-1:0] cnt_ext;

  assign in_acc   = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == StIdle);

  assign ins_pos = cnt_q + AW'(1);
  assign up      = pos_q >> 1;
  assign child_l = {pos_q, 1'b0};
  assign child_r = {pos_q, 1'b1};
  assign n_ext   = {1'b0, cnt_q};
  assign use_r   = (child_r <= n_ext) && (rd_a.prio > rd_b.prio);
  assign c_sel   = use_r ? child_r : child_l;
  assign c_val   = use_r ? rd_b : rd_a;
  assign cc_l    = {c_sel[AW-1:0], 1'b0};
  assign cnt_ext = CXW'(cnt_q);

  bhpq_ram #(
    .Width (EntryW),
    .Depth (HeapDepth)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (ram_ra_a),
    .raddr_b_i (ram_ra_b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    pos_d     = pos_q;
    new_d     = new_q;
    top_d     = top_q;
    status_d  = status_q;
    ram_we    = 1'b0;
    ram_waddr = pos_q;
    ram_wdata = new_q;
    ram_ra_a  = '0;
    ram_ra_b  = '0;
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          new_d.prio = req_i.entry_priority;
          new_d.data = req_i.entry_data;
          top_d      = '0;
          status_d   = StatusOk;
          if (req_i.command == CmdInsert) begin
            if (cnt_q == AW'(HeapDepth - 1)) begin
              status_d = StatusFull;
              state_d  = StDone;
            end else begin
              cnt_d = ins_pos;
              pos_d = ins_pos;
              if (cnt_q != '0) begin
                ram_ra_a = ins_pos >> 1;
                state_d  = StUp;
              end else begin
                state_d = StFin;
              end
            end
          end else begin
            if (cnt_q == '0) begin
              status_d = StatusEmpty;
              state_d  = StDone;
            end else begin
              cnt_d    = cnt_q - AW'(1);
              ram_ra_a = AW'(1);
              ram_ra_b = cnt_q;
              state_d  = StDnLoad;
            end
          end
        end
      end
      StUp: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q;
        if (new_q.prio < rd_a.prio) begin
          ram_wdata = rd_a;
          pos_d     = up;
          if (up > AW'(1)) begin
            ram_ra_a = up >> 1;
          end else begin
            state_d = StFin;
          end
        end else begin
          ram_wdata = new_q;
          state_d   = StDone;
        end
      end
      StDnLoad: begin
        top_d = rd_a.data;
        new_d = rd_b;
        pos_d = AW'(1);
        if (cnt_q >= AW'(2)) begin
          ram_ra_a = AW'(2);
          ram_ra_b = AW'(3);
          state_d  = StDnCmp;
        end else begin
          state_d = StFin;
        end
      end
      StDnCmp: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q;
        if (new_q.prio <= c_val.prio) begin
          ram_wdata = new_q;
          state_d   = StDone;
        end else begin
          ram_wdata = c_val;
          pos_d     = c_sel[AW-1:0];
          if (cc_l <= n_ext) begin
            ram_ra_a = cc_l[AW-1:0];
            ram_ra_b = cc_l[AW-1:0] | AW'(1);
          end else begin
            state_d = StFin;
          end
        end
      end
      StFin: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q;
        ram_wdata = new_q;
        state_d   = StDone;
      end
      StDone: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    new_q    <= new_d;
    top_q    <= top_d;
    status_q <= status_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == StDone && out_free) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StDone && out_free) begin
      out_data_q   <= top_q;
      out_status_q <= status_q;
      out_cnt_q    <= cnt_ext[CountW-1:0];
      out_empty_q  <= (cnt_q == '0);
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.removed_data = out_data_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.entry_count  = out_cnt_q;
  assign rsp_o.is_empty     = out_empty_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= AW'(HeapDepth - 1))
    else $error("entry count above capacity");

  a_we_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == StUp || state_q == StDnCmp || state_q == StFin))
    else $error("heap RAM written outside a sift or final write");

  a_pos_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StUp || state_q == StDnCmp || state_q == StFin) |-> pos_q != '0)
    else $error("sift position at unused slot zero");

  a_empty_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && req_i.command == CmdRemove && cnt_q == '0) |=>
      (state_q == StDone && status_q == StatusEmpty && $stable(cnt_q)))
    else $error("remove on empty heap not flagged");

  a_full_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && req_i.command == CmdInsert && cnt_q == AW'(HeapDepth - 1)) |=>
      (state_q == StDone && status_q == StatusFull && $stable(cnt_q)))
    else $error("insert on full heap not flagged");

endmodule
